// ----- sv/lbm_pkg.sv -----
// ----------------------------------------------------------------------------
// lbm_pkg
// Shared types and constants for the 2x2x2 label block mode pipeline.
// ----------------------------------------------------------------------------
package lbm_pkg;

	localparam int LABEL_BITS  = 16;
	localparam int OUT_BITS    = 16;
	localparam int NUM_CORNERS = 8;
	localparam int IDX_BITS    = $clog2(NUM_CORNERS);
	localparam int IN_BYTES    = (NUM_CORNERS * LABEL_BITS + 7) / 8;
	localparam int OUT_BYTES   = (OUT_BITS + 7) / 8;

	// Corner 7 is the fallback when no group of four, triple or pair among the first seven corners matches.
	localparam logic [IDX_BITS-1:0] LAST_CORNER = IDX_BITS'(NUM_CORNERS - 1);

	typedef logic [LABEL_BITS-1:0]                  label_t;
	typedef label_t [NUM_CORNERS-1:0]               labels_t;
	typedef logic [IDX_BITS-1:0]                    idx_t;
	typedef logic [NUM_CORNERS-1:0][NUM_CORNERS-1:0] eq_t;

	// Stage 1 payload: labels plus the upper triangle of the equality matrix.
	typedef struct packed {
		labels_t labels;
		eq_t     eq;
	} cmp_t;

	// Stage 2 payload: labels plus the index of the winning corner.
	typedef struct packed {
		labels_t labels;
		idx_t    sel;
	} pick_t;

endpackage

// ----- sv/lbm_cmp.sv -----
// ----------------------------------------------------------------------------
// lbm_cmp
// First pipeline stage: compares every pair of corner labels.
// ----------------------------------------------------------------------------
module lbm_cmp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lbm_pkg::labels_t in_labels,
	output logic             out_valid,
	input  logic             out_ready,
	output lbm_pkg::cmp_t    out_data
);
	import lbm_pkg::*;

	logic valid_s1;
	cmp_t data_s1;
	eq_t  eq_d;

	// Only pairs with i < j are needed; the rest of the matrix stays zero.
	always_comb begin
		eq_d = '0;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			for (int j = i + 1; j < NUM_CORNERS; j++) begin
				eq_d[i][j] = (in_labels[i] == in_labels[j]);
			end
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1.labels <= in_labels;
			data_s1.eq     <= eq_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ----- sv/lbm_pick.sv -----
// ----------------------------------------------------------------------------
// lbm_pick
// Second pipeline stage: finds the winning corner by match priority.
// ----------------------------------------------------------------------------
module lbm_pick (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lbm_pkg::cmp_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output lbm_pkg::pick_t out_data
);
	import lbm_pkg::*;

	logic  valid_s2;
	pick_t data_s2;
	logic  quad_hit;
	logic  tri_hit;
	logic  pair_hit;
	idx_t  quad_idx;
	idx_t  tri_idx;
	idx_t  pair_idx;
	idx_t  sel_d;
	logic  dup_s2;

	// Each search keeps the first match in lexicographic index order. All
	// members of a match equal the lowest one, so only that index is kept.
	always_comb begin
		quad_hit = 1'b0;
		quad_idx = '0;
		tri_hit  = 1'b0;
		tri_idx  = '0;
		pair_hit = 1'b0;
		pair_idx = '0;
		for (int a = 0; a < NUM_CORNERS; a++) begin
			for (int b = a + 1; b < NUM_CORNERS; b++) begin
				for (int c = b + 1; c < NUM_CORNERS; c++) begin
					for (int d = c + 1; d < NUM_CORNERS; d++) begin
						if (!quad_hit && in_data.eq[a][b] && in_data.eq[a][c]
								&& in_data.eq[a][d]) begin
							quad_hit = 1'b1;
							quad_idx = IDX_BITS'(a);
						end
					end
					if (!tri_hit && in_data.eq[a][b] && in_data.eq[a][c]) begin
						tri_hit = 1'b1;
						tri_idx = IDX_BITS'(a);
					end
				end
				// The last corner takes no part in the pair search.
				if (!pair_hit && (b < NUM_CORNERS - 1) && in_data.eq[a][b]) begin
					pair_hit = 1'b1;
					pair_idx = IDX_BITS'(a);
				end
			end
		end
		if (quad_hit) begin
			sel_d = quad_idx;
		end else if (tri_hit) begin
			sel_d = tri_idx;
		end else if (pair_hit) begin
			sel_d = pair_idx;
		end else begin
			sel_d = LAST_CORNER;
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2.labels <= in_data.labels;
			data_s2.sel    <= sel_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	// True when the chosen label also sits in some other corner.
	always_comb begin
		dup_s2 = 1'b0;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			if (IDX_BITS'(i) != data_s2.sel
					&& data_s2.labels[i] == data_s2.labels[data_s2.sel]) begin
				dup_s2 = 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_pick_has_match: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && data_s2.sel != LAST_CORNER) |-> dup_s2)
		else $error("picked corner has no matching corner");
	a_pick_low_first: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.eq[0][1] && in_data.eq[0][2]
			&& in_data.eq[0][3]) |=> (data_s2.sel == '0))
		else $error("first group of four not chosen");
`endif

endmodule

// ----- sv/lbm_sel.sv -----
// ----------------------------------------------------------------------------
// lbm_sel
// Third pipeline stage: selects the winning label into the output register.
// ----------------------------------------------------------------------------
module lbm_sel (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  lbm_pkg::pick_t                 in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [lbm_pkg::OUT_BITS-1:0]   out_label
);
	import lbm_pkg::*;

	logic                valid_s3;
	logic [OUT_BITS-1:0] label_s3;

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			label_s3 <= OUT_BITS'(in_data.labels[in_data.sel]);
		end
	end

	assign out_valid = valid_s3;
	assign out_label = label_s3;

endmodule

// ----- sv/label_block_mode_2x2x2_unit.sv -----
// ----------------------------------------------------------------------------
// label_block_mode_2x2x2_unit
// Picks the dominant label of one 2x2x2 voxel cube per item.
// ----------------------------------------------------------------------------
// Each accepted item is registered in stage 1, then stage 2, then stage 3;
// m_axis_tvalid rises once the item sits in stage 3, the output register.
// One item per cycle unless stalled; each of the three stages holds one item.
// A stall on the output holds every full stage and backs up to s_axis_tready.
// Reset (arst_n low, asynchronous) empties all stages; payload is not cleared.
// ----------------------------------------------------------------------------
module label_block_mode_2x2x2_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input item: eight corner labels.
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// Fields from bit 0 up: corner_000, corner_100, corner_010, corner_110,
	// corner_001, corner_101, corner_011, corner_111 (16 bits each).
	input  logic [lbm_pkg::IN_BYTES*8-1:0]       s_axis_tdata,
	// Result item: one label.
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// Fields from bit 0 up: mode_label (16 bits).
	output logic [lbm_pkg::OUT_BYTES*8-1:0]      m_axis_tdata
);
	import lbm_pkg::*;

	// The pipeline has three stages, each a register with its own valid bit.
	// Stage 1 compares all 28 pairs of corners. Stage 2 runs the three
	// priority searches (groups of four, then triples, then pairs among the
	// first seven corners) over the equality bits and keeps the winning
	// corner index. Stage 3 muxes that corner's label into the output
	// register. Every stage is ready when it is empty or its item moves on,
	// so the chain of ready signals runs back from m_axis_tready.

	labels_t             in_labels;
	logic                valid_1;
	logic                ready_2;
	cmp_t                data_1;
	logic                valid_2;
	logic                ready_3;
	pick_t               data_2;
	logic [OUT_BITS-1:0] mode_label;

	// Unpack the corners; corner_000 sits in the lowest bits.
	always_comb begin
		for (int i = 0; i < NUM_CORNERS; i++) begin
			in_labels[i] = s_axis_tdata[i*LABEL_BITS +: LABEL_BITS];
		end
	end

	lbm_cmp u_cmp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_labels (in_labels),
		.out_valid (valid_1),
		.out_ready (ready_2),
		.out_data  (data_1)
	);

	lbm_pick u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_1),
		.in_ready  (ready_2),
		.in_data   (data_1),
		.out_valid (valid_2),
		.out_ready (ready_3),
		.out_data  (data_2)
	);

	lbm_sel u_sel (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_2),
		.in_ready  (ready_3),
		.in_data   (data_2),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_label (mode_label)
	);

	// The result field fills the output bus; pad any spare bits with zeros.
	assign m_axis_tdata = (OUT_BYTES*8)'(mode_label);

`ifndef ASSERT_OFF
	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_1)
		else $error("accepted item did not reach stage 1");
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_1 && !ready_2) |=> (valid_1 && $stable(data_1)))
		else $error("stage 1 item changed while stalled");
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_2 && !ready_3) |=> (valid_2 && $stable(data_2)))
		else $error("stage 2 item changed while stalled");
`endif

endmodule
